/* rtl/light_sensor_brightness_mapper_core_macros.svh */
// assertion macros used by the checker file of the brightness mapper
// no dependencies; include by bare file name
`ifndef LIGHT_SENSOR_BRIGHTNESS_MAPPER_CORE_MACROS_SVH
`define LIGHT_SENSOR_BRIGHTNESS_MAPPER_CORE_MACROS_SVH

// antecedent in this cycle implies consequent in the same cycle
`define LSBM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent in this cycle implies consequent in the next cycle
`define LSBM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/lsbm_pkg.sv */
// shared widths, register indexes and constants of the light sensor brightness mapper
// no dependencies
`timescale 1ns / 1ps

package lsbm_pkg;

   localparam int SAMPLE_W   = 12;   // light sample and average width
   localparam int LEVEL_W    = 8;    // brightness width
   localparam int DVS_W      = 12;   // divisor width of the shared divider
   localparam int PROD_W     = 20;   // magnitude of the map product
   localparam int MAP_W      = 22;   // signed working width of the map
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [SAMPLE_W-1:0] DARK_RESET   = 12'd0;
   localparam logic [SAMPLE_W-1:0] BRIGHT_RESET = 12'd4095;
   localparam logic [LEVEL_W-1:0]  MIN_RESET    = 8'd10;
   localparam logic [LEVEL_W-1:0]  MAX_RESET    = 8'd255;

   // register index, taken from the word address of the configuration port
   typedef enum logic [1:0] {
      REG_DARK,
      REG_BRIGHT,
      REG_MIN,
      REG_MAX
   } reg_idx_type;

endpackage

/* rtl/lsbm_ring.sv */
// sample ring memory: one write port, one registered read port
// uses lsbm_pkg for the sample width
`timescale 1ns / 1ps

module lsbm_ring #(
   parameter int WINDOW = 16,
   parameter int SLOT_W = 4
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [SLOT_W-1:0]              wr_addr,
   input  logic [lsbm_pkg::SAMPLE_W-1:0]  wr_data,
   input  logic                           rd_en,
   input  logic [SLOT_W-1:0]              rd_addr,
   output logic [lsbm_pkg::SAMPLE_W-1:0]  rd_data
);
   import lsbm_pkg::*;

   logic [SAMPLE_W-1:0] mem_ff [WINDOW];
   logic [SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/lsbm_div.sv */
// shared restoring divider, one quotient bit per cycle
// uses lsbm_pkg for the divisor width
`timescale 1ns / 1ps

module lsbm_div #(
   parameter int DVD_W = 20
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [DVD_W-1:0]             dividend,
   input  logic [lsbm_pkg::DVS_W-1:0]   divisor,
   output logic                         done,
   output logic [DVD_W-1:0]             quotient
);
   import lsbm_pkg::*;

   localparam int STEP_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0]  dvd_ff;
   logic [DVS_W-1:0]  dvs_ff;
   logic [DVS_W-1:0]  rem_ff;
   logic [STEP_W-1:0] step_ff;
   logic              busy_ff;
   logic              done_ff;

   logic [DVS_W:0]    trial;
   logic [DVS_W:0]    diff;
   logic              ge;
   logic [DVS_W-1:0]  rem_in;

   assign trial  = {rem_ff, dvd_ff[DVD_W-1]};
   assign diff   = trial - {1'b0, dvs_ff};
   assign ge     = (trial >= {1'b0, dvs_ff});
   // remainder stays below the divisor, so the difference fits
   assign rem_in = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= !start && busy_ff && (step_ff == STEP_W'(1));
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_W'(DVD_W);
         end else if (busy_ff) begin
            step_ff <= step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dvs_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[DVD_W-2:0], ge};
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

/* rtl/light_sensor_brightness_mapper_core.sv */
// light sensor brightness mapper: windowed mean of light samples, linear map, clamp
// each division yields D = max(12 + clog2(WINDOW+1), 20) quotient bits, the dividend width
// a new sample is taken only once the previous result has been registered
// the sum loop reads one ring entry a cycle, the shared divider gives one bit a cycle
// reset clears write slot, fill flag, sequencer and handshakes; registers take defaults
// ring contents are undefined after reset and are only read once written
`timescale 1ns / 1ps

module light_sensor_brightness_mapper_core #(
   parameter int WINDOW = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [lsbm_pkg::SAMPLE_W-1:0]    req_light_sample,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [lsbm_pkg::LEVEL_W-1:0]     rsp_brightness_level,
   output logic [lsbm_pkg::SAMPLE_W-1:0]    rsp_average_level,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [lsbm_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [lsbm_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [lsbm_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import lsbm_pkg::*;

   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int SUM_W  = SAMPLE_W + CNT_W;
   localparam int DVD_W  = (SUM_W > PROD_W) ? SUM_W : PROD_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_AVG_DIV,
      ST_MUL,
      ST_MAP_START,
      ST_MAP_DIV,
      ST_CLAMP
   } state_type;

   // configuration registers
   logic [SAMPLE_W-1:0] dark_ff;
   logic [SAMPLE_W-1:0] bright_ff;
   logic [LEVEL_W-1:0]  minb_ff;
   logic [LEVEL_W-1:0]  maxb_ff;
   reg_idx_type         csr_idx;
   logic                csr_wr;

   // sequencer state
   state_type                 state_ff;
   logic [SLOT_W-1:0]         slot_ff;
   logic                      filled_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic [CNT_W-1:0]          idx_ff;
   logic                      rd_pend_ff;
   logic [SUM_W-1:0]          sum_ff;
   logic [SAMPLE_W-1:0]       avg_ff;
   logic signed [MAP_W-1:0]   prod_ff;
   logic signed [MAP_W-1:0]   v_ff;
   logic                      neg_ff;
   logic                      div_start_ff;
   logic [DVD_W-1:0]          div_dvd_ff;
   logic [DVS_W-1:0]          div_dvs_ff;
   logic                      rsp_valid_ff;
   logic [LEVEL_W-1:0]        rsp_level_ff;
   logic [SAMPLE_W-1:0]       rsp_avg_ff;

   // datapath
   logic                      accept;
   logic                      rd_en;
   logic [SAMPLE_W-1:0]       rd_data;
   logic                      div_done;
   logic [DVD_W-1:0]          div_quot;
   logic signed [SAMPLE_W:0]  diff_a;
   logic signed [LEVEL_W:0]   diff_o;
   logic signed [SAMPLE_W:0]  span;
   logic [SAMPLE_W:0]         span_mag;
   logic signed [MAP_W-1:0]   prod_in;
   logic [MAP_W-1:0]          prod_mag;
   logic signed [MAP_W-1:0]   quot_s;
   logic signed [MAP_W-1:0]   min_s;
   logic signed [MAP_W-1:0]   max_s;
   logic                      out_free;

   assign accept   = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign rd_en    = (state_ff == ST_SUM) && (idx_ff != cnt_ff);

   // ---------------- configuration port ----------------
   assign csr_idx    = reg_idx_type'(csr_paddr[3:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dark_ff   <= DARK_RESET;
         bright_ff <= BRIGHT_RESET;
         minb_ff   <= MIN_RESET;
         maxb_ff   <= MAX_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_DARK:   dark_ff   <= csr_pwdata[SAMPLE_W-1:0];
            REG_BRIGHT: bright_ff <= csr_pwdata[SAMPLE_W-1:0];
            REG_MIN:    minb_ff   <= csr_pwdata[LEVEL_W-1:0];
            REG_MAX:    maxb_ff   <= csr_pwdata[LEVEL_W-1:0];
            default:    dark_ff   <= dark_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_DARK:   csr_prdata = CSR_DATA_W'(dark_ff);
         REG_BRIGHT: csr_prdata = CSR_DATA_W'(bright_ff);
         REG_MIN:    csr_prdata = CSR_DATA_W'(minb_ff);
         REG_MAX:    csr_prdata = CSR_DATA_W'(maxb_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // ---------------- ring and divider ----------------
   lsbm_ring #(
      .WINDOW (WINDOW),
      .SLOT_W (SLOT_W)
   ) u_ring (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (slot_ff),
      .wr_data (req_light_sample),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[SLOT_W-1:0]),
      .rd_data (rd_data)
   );

   lsbm_div #(
      .DVD_W (DVD_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_dvd_ff),
      .divisor  (div_dvs_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // ---------------- map arithmetic ----------------
   assign diff_a   = $signed({1'b0, avg_ff}) - $signed({1'b0, dark_ff});
   assign diff_o   = $signed({1'b0, maxb_ff}) - $signed({1'b0, minb_ff});
   assign prod_in  = MAP_W'(diff_a) * MAP_W'(diff_o);
   assign span     = $signed({1'b0, bright_ff}) - $signed({1'b0, dark_ff});
   assign span_mag = span[SAMPLE_W] ? (SAMPLE_W + 1)'(1'b0) - span : span;
   assign prod_mag = prod_ff[MAP_W-1] ? MAP_W'(1'b0) - prod_ff : prod_ff;
   assign quot_s   = MAP_W'(div_quot);
   assign min_s    = MAP_W'(minb_ff);
   assign max_s    = MAP_W'(maxb_ff);

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         filled_ff    <= 1'b0;
         rd_pend_ff   <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // divider starts once the sum is complete, and for the map unless the span is zero
         div_start_ff <= ((state_ff == ST_SUM) && !rd_en && !rd_pend_ff)
                         || ((state_ff == ST_MAP_START) && (dark_ff != bright_ff));
         if ((state_ff == ST_CLAMP) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  // mean covers every entry once the ring has wrapped
                  cnt_ff     <= filled_ff ? CNT_W'(WINDOW) : CNT_W'(slot_ff) + 1'b1;
                  idx_ff     <= '0;
                  sum_ff     <= '0;
                  rd_pend_ff <= 1'b0;
                  if (slot_ff == SLOT_W'(WINDOW - 1)) begin
                     slot_ff   <= '0;
                     filled_ff <= 1'b1;
                  end else begin
                     slot_ff <= slot_ff + 1'b1;
                  end
                  state_ff <= ST_SUM;
               end
            end
            ST_SUM: begin
               // read data comes from a registered port and is added in the cycle after its address
               if (rd_pend_ff) begin
                  sum_ff <= sum_ff + SUM_W'(rd_data);
               end
               rd_pend_ff <= rd_en;
               if (rd_en) begin
                  idx_ff <= idx_ff + 1'b1;
               end else if (!rd_pend_ff) begin
                  div_dvd_ff <= DVD_W'(sum_ff);
                  div_dvs_ff <= DVS_W'(cnt_ff);
                  state_ff   <= ST_AVG_DIV;
               end
            end
            ST_AVG_DIV: begin
               if (div_done) begin
                  avg_ff   <= div_quot[SAMPLE_W-1:0];
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               prod_ff  <= prod_in;
               state_ff <= ST_MAP_START;
            end
            ST_MAP_START: begin
               if (dark_ff == bright_ff) begin
                  v_ff     <= min_s;
                  state_ff <= ST_CLAMP;
               end else begin
                  // divide magnitudes, then apply the sign: truncates toward zero
                  neg_ff     <= prod_ff[MAP_W-1] ^ span[SAMPLE_W];
                  div_dvd_ff <= DVD_W'(prod_mag);
                  div_dvs_ff <= span_mag[DVS_W-1:0];
                  state_ff   <= ST_MAP_DIV;
               end
            end
            ST_MAP_DIV: begin
               if (div_done) begin
                  v_ff     <= (neg_ff ? MAP_W'(1'b0) - quot_s : quot_s) + min_s;
                  state_ff <= ST_CLAMP;
               end
            end
            ST_CLAMP: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // result register; lower bound is tested first
   always_ff @(posedge clock) begin
      if ((state_ff == ST_CLAMP) && out_free) begin
         rsp_avg_ff <= avg_ff;
         priority if (v_ff < min_s) begin
            rsp_level_ff <= minb_ff;
         end else if (v_ff > max_s) begin
            rsp_level_ff <= maxb_ff;
         end else begin
            rsp_level_ff <= v_ff[LEVEL_W-1:0];
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_brightness_level = rsp_level_ff;
   assign rsp_average_level    = rsp_avg_ff;

endmodule

/* rtl/lsbm_checker.sv */
// port-level checks of the brightness mapper and their bind to the top level
// uses lsbm_pkg widths and the assertion macros
`timescale 1ns / 1ps
`include "light_sensor_brightness_mapper_core_macros.svh"

module lsbm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [lsbm_pkg::LEVEL_W-1:0]    rsp_brightness_level,
   input logic [lsbm_pkg::SAMPLE_W-1:0]   rsp_average_level
);
   import lsbm_pkg::*;

   // a waiting result holds its value
   `LSBM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_brightness_level) && $stable(rsp_average_level), "result changed while stalled")

   // one item at a time: busy right after an item is taken
   `LSBM_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "second item taken while busy")

   // a new result only comes out of a busy sequencer
   `LSBM_ASSERT_NOW(a_result_from_busy, clock, reset, $rose(rsp_valid), $past(!req_ready), "result appeared without work")

endmodule

bind light_sensor_brightness_mapper_core lsbm_checker u_lsbm_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_ready            (req_ready),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_brightness_level (rsp_brightness_level),
   .rsp_average_level    (rsp_average_level)
);

/* bench/tb_top.sv */
// testbench for light_sensor_brightness_mapper_core: windowed light average mapped to brightness
// depends on lsbm_pkg and the core; a small checker class predicts each result in order
`timescale 1ns / 1ps

module tb_top;
   import lsbm_pkg::*;

   localparam int WINDOW = 16;
   localparam int RANDOM_PHASES = 16;
   localparam int PHASE_ITEMS = 100;

   typedef struct packed {
      logic [LEVEL_W-1:0]  level;
      logic [SAMPLE_W-1:0] average;
   } level_pair_type;

   class brightness_checker;
      logic [SAMPLE_W-1:0] ring [WINDOW];
      int unsigned         slot;
      bit                  filled;
      logic [SAMPLE_W-1:0] dark, bright;
      logic [LEVEL_W-1:0]  min_lvl, max_lvl;
      level_pair_type      pending_levels[$];
      int                  mismatches;
      int                  samples_seen;
      int                  levels_checked;

      function new();
         slot = 0;
         filled = 0;
         dark = DARK_RESET;
         bright = BRIGHT_RESET;
         min_lvl = MIN_RESET;
         max_lvl = MAX_RESET;
         mismatches = 0;
         samples_seen = 0;
         levels_checked = 0;
      endfunction

      function void set_reg(reg_idx_type idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            REG_DARK:   dark = val[SAMPLE_W-1:0];
            REG_BRIGHT: bright = val[SAMPLE_W-1:0];
            REG_MIN:    min_lvl = val[LEVEL_W-1:0];
            REG_MAX:    max_lvl = val[LEVEL_W-1:0];
            default: ;
         endcase
      endfunction

      // store the sample, average the filled part of the ring, map and clamp
      function void take_sample(logic [SAMPLE_W-1:0] s);
         int unsigned    count, sum, i;
         int             avg, lo, hi, omin, omax, v;
         level_pair_type e;
         ring[slot] = s;
         slot++;
         if (slot == WINDOW) begin
            slot = 0;
            filled = 1;
         end
         count = filled ? WINDOW : slot;
         sum = 0;
         for (i = 0; i < count; i++)
            sum += 32'(ring[i]);
         avg = sum / count;
         lo = int'(dark);
         hi = int'(bright);
         omin = int'(min_lvl);
         omax = int'(max_lvl);
         // int division truncates toward zero, negative spans included
         if (lo == hi)
            v = omin;
         else
            v = (avg - lo) * (omax - omin) / (hi - lo) + omin;
         // lower bound wins its test first, so min above max gives max unless below min
         if (v < omin)
            v = omin;
         else if (v > omax)
            v = omax;
         e.level = v[LEVEL_W-1:0];
         e.average = avg[SAMPLE_W-1:0];
         pending_levels.push_back(e);
         samples_seen++;
      endfunction

      function void check_level(logic [LEVEL_W-1:0] lvl, logic [SAMPLE_W-1:0] avg);
         level_pair_type e;
         if (pending_levels.size() == 0) begin
            $display("%0t: result level %0d average %0d with no sample pending",
                     $time, lvl, avg);
            mismatches++;
            return;
         end
         e = pending_levels.pop_front();
         levels_checked++;
         if (lvl !== e.level) begin
            $display("%0t: brightness_level expected %0d actual %0d", $time, e.level, lvl);
            mismatches++;
         end
         if (avg !== e.average) begin
            $display("%0t: average_level expected %0d actual %0d", $time, e.average, avg);
            mismatches++;
         end
      endfunction

      function int outstanding();
         return pending_levels.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [SAMPLE_W-1:0]   req_light_sample = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [LEVEL_W-1:0]    rsp_brightness_level;
   logic [SAMPLE_W-1:0]   rsp_average_level;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   brightness_checker checker_h;
   bit                quiet = 0;
   bit                hold_request = 0;
   int                gap_pct = 0;
   int                stall_pct = 0;
   int                settings_used = 0;
   logic [SAMPLE_W-1:0] cur_dark = DARK_RESET;
   logic [SAMPLE_W-1:0] cur_bright = BRIGHT_RESET;

   light_sensor_brightness_mapper_core #(.WINDOW(WINDOW)) uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_light_sample     (req_light_sample),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_brightness_level (rsp_brightness_level),
      .rsp_average_level    (rsp_average_level),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_prdata           (csr_prdata),
      .csr_pready           (csr_pready)
   );

   always #1 clock = ~clock;

   initial begin
      #3_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // result side: check at each edge, then pick ready for the next cycle
   initial begin
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            checker_h.check_level(rsp_brightness_level, rsp_average_level);
         if (hold_request) begin
            hold_request = 0;
            hold_left = 500;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(1, 18) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_sample(logic [SAMPLE_W-1:0] s);
      req_valid <= 1'b1;
      req_light_sample <= s;
      do @(posedge clock); while (!req_ready);
      checker_h.take_sample(s);
   endtask

   task automatic pause_sender(int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (checker_h.outstanding() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // setup and access cycles; psel stays up across back-to-back writes
   task automatic write_reg(reg_idx_type idx, logic [CSR_DATA_W-1:0] val);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      checker_h.set_reg(idx, val);
   endtask

   // noisy puts random bits above each register's width
   task automatic configure(int d, int b, int mn, int mx, bit noisy);
      logic [CSR_DATA_W-1:0] hi12, hi8;
      hi12 = noisy ? ($urandom() << SAMPLE_W) : '0;
      hi8 = noisy ? ($urandom() << LEVEL_W) : '0;
      wait_drained();
      write_reg(REG_DARK, hi12 | d);
      write_reg(REG_BRIGHT, hi12 | b);
      write_reg(REG_MIN, hi8 | mn);
      write_reg(REG_MAX, hi8 | mx);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      cur_dark = SAMPLE_W'(d);
      cur_bright = SAMPLE_W'(b);
      settings_used++;
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return SAMPLE_W'($urandom_range(0, 31));
         3: return SAMPLE_W'(4095 - $urandom_range(0, 31));
         4: return SAMPLE_W'(cur_dark + $urandom_range(0, 8) - 4);
         5: return SAMPLE_W'(cur_bright + $urandom_range(0, 8) - 4);
         default: return SAMPLE_W'($urandom_range(0, 4095));
      endcase
   endfunction

   task automatic random_settings();
      int d, b, mn, mx;
      d = $urandom_range(0, 4095);
      b = $urandom_range(0, 4095);
      mn = $urandom_range(0, 255);
      mx = $urandom_range(0, 255);
      case ($urandom_range(0, 6))
         0: b = d;
         1: begin
            d = $urandom_range(1, 4095);
            b = $urandom_range(0, d - 1);
         end
         2: begin
            d = 0;
            b = 4095;
            mn = 0;
            mx = 255;
         end
         3: begin
            mn = $urandom_range(1, 255);
            mx = $urandom_range(0, mn - 1);
         end
         4: mx = mn;
         default: ;
      endcase
      configure(d, b, mn, mx, 1'($urandom_range(0, 1)));
   endtask

   initial begin
      int phase, k;
      checker_h = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: field extremes and alternating bits
      send_sample(12'd0);
      send_sample(12'hFFF);
      send_sample(12'hAAA);
      send_sample(12'h555);
      send_sample(12'hFFF);
      // equal dark and bright levels
      configure(2000, 2000, 40, 200, 0);
      send_sample(12'd0);
      send_sample(12'hFFF);
      send_sample(12'd2000);
      // dark above bright, negative span
      configure(4095, 0, 0, 255, 0);
      send_sample(12'hFFF);
      send_sample(12'd0);
      send_sample(12'd1000);
      send_sample(12'd3000);
      // min above max brightness
      configure(0, 4095, 200, 50, 0);
      send_sample(12'd0);
      send_sample(12'hFFF);
      send_sample(12'd2048);
      send_sample(12'd100);
      // steepest span with the top level pinned, then the bottom level pinned
      configure(0, 1, 255, 255, 0);
      send_sample(12'd0);
      send_sample(12'hFFF);
      configure(100, 4000, 0, 0, 0);
      send_sample(12'hFFF);
      send_sample(12'd0);

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         random_settings();
         quiet = (phase >= RANDOM_PHASES - 2);
         gap_pct = quiet ? 0 : (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 10 : 40;
         stall_pct = quiet ? 0 : (phase % 4 == 2) ? 0 : 30;
         // long result hold-off while samples keep coming
         if (phase == 3) begin
            gap_pct = 0;
            hold_request = 1;
         end
         for (k = 0; k < PHASE_ITEMS; k++) begin
            if (!quiet && $urandom_range(0, 99) < gap_pct)
               pause_sender($urandom_range(1, 18));
            send_sample(pick_sample());
         end
      end

      wait_drained();
      repeat (100) @(posedge clock);
      $display("run covered %0d samples and %0d results across %0d register settings",
               checker_h.samples_seen, checker_h.levels_checked, settings_used + 1);
      $display("including equal and reversed levels, min above max and a long result stall");
      if (checker_h.mismatches == 0 && checker_h.outstanding() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
